// ----- rtl/core/bmcr_pkg.sv -----
// Shared constants, types and state codes for the best-match conflict resolver.
// Used by the slot store, the top level and the checker; it depends on nothing else.
package bmcr_pkg;

    localparam int TRAIN_DEPTH = 4096;
    localparam int QUERY_DEPTH = 4096;
    localparam int DIST_BITS   = 24;

    localparam int TRAIN_BITS = $clog2(TRAIN_DEPTH);
    localparam int QUERY_BITS = $clog2(QUERY_DEPTH);
    localparam int COUNT_BITS = $clog2(TRAIN_DEPTH + 1);

    localparam logic [DIST_BITS-1:0] DIST_EMPTY = {DIST_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = COUNT_BITS'(TRAIN_DEPTH);
    localparam logic [COUNT_BITS-1:0] COUNT_RESET = COUNT_BITS'(TRAIN_DEPTH);

    // Stream payload layout, lowest field first, padded to whole bytes.
    localparam int S_FIELDS_W = 1 + TRAIN_BITS + DIST_BITS;
    localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = QUERY_BITS + TRAIN_BITS + DIST_BITS;
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    localparam logic OP_QUERY = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef struct packed {
        logic [QUERY_BITS-1:0] query;
        logic [DIST_BITS-1:0]  distance;
    } slot_entry_t;

    typedef struct packed {
        logic                  en;
        logic [TRAIN_BITS-1:0] addr;
        slot_entry_t           entry;
    } slot_wr_t;

    typedef enum logic [0:0] {
        S_IDLE,
        S_MODIFY
    } state_t;

endpackage

// ----- rtl/core/bmcr_slot_store.sv -----
// Slot memory of the conflict resolver: one entry per train slot, query and distance.
// Holds the post-reset clearing sweep; depends on bmcr_pkg.
module bmcr_slot_store (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            rd_en,
    input  logic [bmcr_pkg::TRAIN_BITS-1:0] rd_addr,
    input  bmcr_pkg::slot_wr_t              wr,
    output bmcr_pkg::slot_entry_t           rd_entry,
    output logic                            busy
);

    bmcr_pkg::slot_entry_t mem [bmcr_pkg::TRAIN_DEPTH];

    logic                            busy_reg;
    logic                            busy_next;
    logic [bmcr_pkg::TRAIN_BITS-1:0] clear_addr_reg;
    logic [bmcr_pkg::TRAIN_BITS-1:0] clear_addr_next;
    bmcr_pkg::slot_entry_t           rd_entry_reg;

    logic                            mem_we;
    logic [bmcr_pkg::TRAIN_BITS-1:0] mem_waddr;
    bmcr_pkg::slot_entry_t           mem_wdata;

    always_comb
    begin
        busy_next       = busy_reg;
        clear_addr_next = clear_addr_reg;
        if (busy_reg)
        begin
            clear_addr_next = clear_addr_reg + 1'b1;
            if (clear_addr_reg == bmcr_pkg::TRAIN_BITS'(bmcr_pkg::TRAIN_DEPTH - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    // The sweep owns the write port until every slot reads as empty.
    always_comb
    begin
        if (busy_reg)
        begin
            mem_we             = 1'b1;
            mem_waddr          = clear_addr_reg;
            mem_wdata.query    = '0;
            mem_wdata.distance = bmcr_pkg::DIST_EMPTY;
        end
        else
        begin
            mem_we    = wr.en;
            mem_waddr = wr.addr;
            mem_wdata = wr.entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b1;
            clear_addr_reg <= '0;
        end
        else
        begin
            busy_reg       <= busy_next;
            clear_addr_reg <= clear_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_entry_reg <= mem[rd_addr];
        end
    end

    assign rd_entry = rd_entry_reg;
    assign busy     = busy_reg;

endmodule

// ----- rtl/core/best_match_conflict_resolver.sv -----
// Top level of the best-match conflict resolver: stream ports, item sequencer, output register.
// Depends on bmcr_pkg and bmcr_slot_store.
//
//  Channel   Direction  Handshake                    Payload
//  s_axis    in         s_axis_tvalid/tready          tdata, tuser = operation
//  m_axis    out        m_axis_tvalid/tready          tdata, tuser = found, tlast = batch_done
//  cfg       in         cfg_we (no wait)              cfg_wdata = train_count
//
// Each item first reads its slot from the synchronous slot memory, then in the modify step
// writes back, and compares (query) or loads the result (drain). The read-modify-write of
// one item finishes before the next item is accepted, so no forwarding is needed.
// After reset a clearing sweep marks all 4096 slots empty, one per cycle, and
// s_axis_tready stays low until the sweep is done. A drain whose result finds the
// output register still full waits in the modify step until m_axis takes the result.
module best_match_conflict_resolver (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // match_valid [0], train_index [12:1], match_distance [36:13], zero padding above
    input  logic [bmcr_pkg::S_DATA_W-1:0] s_axis_tdata,
    // operation [0]
    input  logic                          s_axis_tuser,

    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // kept_query [11:0], kept_train [23:12], kept_distance [47:24]
    output logic [bmcr_pkg::M_DATA_W-1:0] m_axis_tdata,
    // found [0]
    output logic                          m_axis_tuser,
    output logic                          m_axis_tlast,

    input  logic                          cfg_we,
    input  logic [bmcr_pkg::COUNT_BITS-1:0] cfg_wdata
);

    localparam int TB = bmcr_pkg::TRAIN_BITS;
    localparam int QB = bmcr_pkg::QUERY_BITS;
    localparam int DB = bmcr_pkg::DIST_BITS;
    localparam int CB = bmcr_pkg::COUNT_BITS;

    bmcr_pkg::state_t state_reg;
    bmcr_pkg::state_t state_next;

    // Item held for the modify step.
    logic          item_op_reg;
    logic          item_op_next;
    logic          item_valid_reg;
    logic          item_valid_next;
    logic [TB-1:0] item_idx_reg;
    logic [TB-1:0] item_idx_next;
    logic [DB-1:0] item_dist_reg;
    logic [DB-1:0] item_dist_next;

    logic [CB-1:0] train_count_reg;
    logic [CB-1:0] train_count_next;
    logic [QB-1:0] query_counter_reg;
    logic [QB-1:0] query_counter_next;
    logic [TB-1:0] drain_ptr_reg;
    logic [TB-1:0] drain_ptr_next;

    // Output register.
    logic          out_valid_reg;
    logic          out_valid_next;
    logic [QB-1:0] out_query_reg;
    logic [QB-1:0] out_query_next;
    logic [TB-1:0] out_train_reg;
    logic [TB-1:0] out_train_next;
    logic [DB-1:0] out_dist_reg;
    logic [DB-1:0] out_dist_next;
    logic          out_found_reg;
    logic          out_found_next;
    logic          out_last_reg;
    logic          out_last_next;

    logic                  in_xfer;
    logic                  out_free;
    logic                  store_busy;
    logic                  rd_en;
    logic [TB-1:0]         rd_addr;
    bmcr_pkg::slot_entry_t rd_entry;
    bmcr_pkg::slot_wr_t    wr;

    logic [CB-1:0] count_eff;
    logic          idx_in_range;
    logic          improves;
    logic          slot_hit;
    logic          drain_last;
    logic          modify_done;

    bmcr_slot_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .wr       (wr),
        .rd_entry (rd_entry),
        .busy     (store_busy)
    );

    // A count of zero behaves as one slot, anything above the depth as the full depth.
    always_comb
    begin
        if (train_count_reg == '0)
        begin
            count_eff = CB'(1);
        end
        else if (train_count_reg > bmcr_pkg::COUNT_MAX)
        begin
            count_eff = bmcr_pkg::COUNT_MAX;
        end
        else
        begin
            count_eff = train_count_reg;
        end
    end

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;

    // Slot decisions, evaluated on the entry read for the held item.
    assign idx_in_range = CB'(item_idx_reg) < count_eff;
    assign improves     = item_valid_reg && idx_in_range && (item_dist_reg < rd_entry.distance);
    assign slot_hit     = rd_entry.distance != bmcr_pkg::DIST_EMPTY;
    assign drain_last   = (CB'(drain_ptr_reg) + CB'(1)) >= count_eff;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bmcr_pkg::S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = bmcr_pkg::S_MODIFY;
                end
            end
            bmcr_pkg::S_MODIFY:
            begin
                if (modify_done)
                begin
                    state_next = bmcr_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bmcr_pkg::S_IDLE;
            end
        endcase
    end

    // Handshake, memory port and modify-step controls.
    always_comb
    begin
        s_axis_tready = 1'b0;
        rd_en         = 1'b0;
        modify_done   = 1'b0;
        wr.en         = 1'b0;
        wr.addr       = item_idx_reg;
        wr.entry      = rd_entry;
        rd_addr       = (s_axis_tuser == bmcr_pkg::OP_DRAIN) ? drain_ptr_reg
                                                               : s_axis_tdata[TB:1];
        case (state_reg)
            bmcr_pkg::S_IDLE:
            begin
                s_axis_tready = !store_busy;
                rd_en         = in_xfer;
            end
            bmcr_pkg::S_MODIFY:
            begin
                if (item_op_reg == bmcr_pkg::OP_DRAIN)
                begin
                    modify_done             = out_free;
                    wr.en                   = out_free;
                    wr.addr                 = drain_ptr_reg;
                    wr.entry.distance       = bmcr_pkg::DIST_EMPTY;
                end
                else
                begin
                    modify_done             = 1'b1;
                    wr.en                   = improves;
                    wr.entry.query          = query_counter_reg;
                    wr.entry.distance       = item_dist_reg;
                end
            end
            default:
            begin
                modify_done = 1'b1;
            end
        endcase
    end

    // Register next values.
    always_comb
    begin
        item_op_next       = item_op_reg;
        item_valid_next    = item_valid_reg;
        item_idx_next      = item_idx_reg;
        item_dist_next     = item_dist_reg;
        train_count_next   = train_count_reg;
        query_counter_next = query_counter_reg;
        drain_ptr_next     = drain_ptr_reg;
        out_valid_next     = out_valid_reg;
        out_query_next     = out_query_reg;
        out_train_next     = out_train_reg;
        out_dist_next      = out_dist_reg;
        out_found_next     = out_found_reg;
        out_last_next      = out_last_reg;

        if (cfg_we)
        begin
            train_count_next = cfg_wdata;
        end

        if (in_xfer)
        begin
            item_op_next    = s_axis_tuser;
            item_valid_next = s_axis_tdata[0];
            item_idx_next   = s_axis_tdata[TB:1];
            item_dist_next  = s_axis_tdata[TB+DB:TB+1];
        end

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (state_reg == bmcr_pkg::S_MODIFY && modify_done)
        begin
            if (item_op_reg == bmcr_pkg::OP_DRAIN)
            begin
                out_valid_next = 1'b1;
                out_query_next = slot_hit ? rd_entry.query : '0;
                out_train_next = drain_ptr_reg;
                out_dist_next  = slot_hit ? rd_entry.distance : '0;
                out_found_next = slot_hit;
                out_last_next  = drain_last;
                if (drain_last)
                begin
                    drain_ptr_next     = '0;
                    query_counter_next = '0;
                end
                else
                begin
                    drain_ptr_next = drain_ptr_reg + 1'b1;
                end
            end
            else
            begin
                // The counter wraps at the query depth, a power of two.
                query_counter_next = query_counter_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= bmcr_pkg::S_IDLE;
            train_count_reg   <= bmcr_pkg::COUNT_RESET;
            query_counter_reg <= '0;
            drain_ptr_reg     <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            train_count_reg   <= train_count_next;
            query_counter_reg <= query_counter_next;
            drain_ptr_reg     <= drain_ptr_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_op_reg    <= item_op_next;
        item_valid_reg <= item_valid_next;
        item_idx_reg   <= item_idx_next;
        item_dist_reg  <= item_dist_next;
        out_query_reg  <= out_query_next;
        out_train_reg  <= out_train_next;
        out_dist_reg   <= out_dist_next;
        out_found_reg  <= out_found_next;
        out_last_reg   <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = bmcr_pkg::M_DATA_W'({out_dist_reg, out_train_reg, out_query_reg});
    assign m_axis_tuser  = out_found_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

// ----- rtl/core/bmcr_checker.sv -----
// Port-level checks for the best-match conflict resolver, bound to its top level.
// Depends on bmcr_pkg and best_match_conflict_resolver.
module bmcr_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          s_axis_tuser,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [bmcr_pkg::M_DATA_W-1:0] m_axis_tdata,
    input logic                          m_axis_tuser,
    input logic                          m_axis_tlast
);

    localparam int DLO = bmcr_pkg::QUERY_BITS + bmcr_pkg::TRAIN_BITS;
    localparam int DHI = DLO + bmcr_pkg::DIST_BITS - 1;

    // One item at a time: no transfer directly after another.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while an item is still being processed");

    // A held result does not change.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
             && $stable(m_axis_tlast)))
        else $error("stalled result changed");

    // An empty slot reports zero query and zero distance; a kept one is never empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            (m_axis_tuser ? (m_axis_tdata[DHI:DLO] != bmcr_pkg::DIST_EMPTY)
                          : (m_axis_tdata[bmcr_pkg::QUERY_BITS-1:0] == '0
                             && m_axis_tdata[DHI:DLO] == '0)))
        else $error("found flag disagrees with reported query or distance");

    // A result rising on an idle output comes from an accepted drain, via the modify step.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |->
            ($past(s_axis_tvalid && s_axis_tready, 2) && $past(s_axis_tuser, 2)))
        else $error("result without a drain transfer");

endmodule

bind best_match_conflict_resolver bmcr_checker u_bmcr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
